>>> src/track_position_predictor_defines.svh
// Assertion macros for the track position predictor.
// Included by the top level; no other dependencies.
`ifndef TRACK_POSITION_PREDICTOR_DEFINES_SVH
`define TRACK_POSITION_PREDICTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("track_position_predictor: check failed");
`define TPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("track_position_predictor: check failed");
`else
`define TPP_ASSERT(lbl, clk, rst, prop)
`define TPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/tpp_pkg.sv
// Shared constants, types and small tables of the track position predictor.
// No dependencies.
`default_nettype none
package tpp_pkg;

  localparam int COORD_BITS = 12;
  localparam int CW         = COORD_BITS + 1;   // centre width
  localparam int DEPTH      = 5;                // centres held, newest included
  localparam int HIST_CELLS = DEPTH - 1;        // older centres kept in cells
  localparam int CNT_W      = 3;
  localparam int SUM_W      = CW + 2;           // sum of four centres
  localparam int NUM_W      = CW + 3;           // rounding numerator
  localparam int PRED_W     = 15;
  localparam int EXT_W      = (CW + 4 > PRED_W + 1) ? CW + 4 : PRED_W + 1;
  localparam int PRED_MAX   = 2 ** (PRED_W - 1) - 1;
  localparam int PRED_MIN   = -(2 ** (PRED_W - 1));

  // floor(2^NUM_W / (2*div)) for each divisor
  localparam logic [NUM_W-1:0] RECIP_BY_2  = NUM_W'((1 << NUM_W) / 2);
  localparam logic [NUM_W-1:0] RECIP_BY_6  = NUM_W'((1 << NUM_W) / 6);
  localparam logic [NUM_W-1:0] RECIP_BY_12 = NUM_W'((1 << NUM_W) / 12);
  localparam logic [NUM_W-1:0] RECIP_BY_20 = NUM_W'((1 << NUM_W) / 20);

  typedef logic [CW-1:0]    center_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0] csum_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Divisor n*(n-1)/2, taken as 1 for a single centre.
  function automatic logic [NUM_W-1:0] half_div(input count_t n);
    logic [NUM_W-1:0] d;
    unique case (n)
      count_t'(3): d = NUM_W'(3);
      count_t'(4): d = NUM_W'(6);
      count_t'(5): d = NUM_W'(10);
      default:     d = NUM_W'(1);
    endcase
    return d;
  endfunction

  function automatic logic [NUM_W-1:0] twice_div(input count_t n);
    return half_div(n) << 1;
  endfunction

  function automatic logic [NUM_W-1:0] recip(input count_t n);
    logic [NUM_W-1:0] m;
    unique case (n)
      count_t'(3): m = RECIP_BY_6;
      count_t'(4): m = RECIP_BY_12;
      count_t'(5): m = RECIP_BY_20;
      default:     m = RECIP_BY_2;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/tpp_cell.sv
// One history cell: holds an older centre pair and adds it to the running sums.
// Depends on tpp_pkg.
`default_nettype none
module tpp_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire tpp_pkg::center_t x_in,
  input  wire tpp_pkg::center_t y_in,
  input  wire logic            active,
  input  wire tpp_pkg::csum_t  sum_x_in,
  input  wire tpp_pkg::csum_t  sum_y_in,
  output tpp_pkg::center_t     x,
  output tpp_pkg::center_t     y,
  output tpp_pkg::csum_t       sum_x,
  output tpp_pkg::csum_t       sum_y
);
  import tpp_pkg::*;

  // advance the history by one place on every accepted item
  always_ff @(posedge clk) begin
    if (shift) begin
      x <= x_in;
      y <= y_in;
    end
  end

  assign sum_x = sum_x_in + (active ? csum_t'(x) : '0);
  assign sum_y = sum_y_in + (active ? csum_t'(y) : '0);

endmodule
`default_nettype wire

>>> src/tpp_axis.sv
// Prediction pipeline for one axis: weighted delta sum, rounded division, clamp.
// Depends on tpp_pkg.
`default_nettype none
module tpp_axis (
  input  wire logic                 clk,
  input  wire tpp_pkg::stage_en_t   en,
  input  wire tpp_pkg::center_t     center,
  input  wire tpp_pkg::csum_t       older,
  input  wire tpp_pkg::count_t      n,
  output tpp_pkg::center_t          center_q,
  output logic signed [tpp_pkg::PRED_W-1:0] predicted
);
  import tpp_pkg::*;

  center_t          c1, c2, c3;
  csum_t            older1;
  count_t           n1, n2, n3;
  csum_t            scaled;
  logic signed [NUM_W-1:0] total;
  logic             neg, neg2, neg3;
  logic [NUM_W-1:0] mag, num, num2, num3;
  logic [2*NUM_W-1:0] prod, back;
  logic [NUM_W-1:0] q0, rem, quo;
  logic signed [EXT_W-1:0] offset, p_full;
  logic signed [PRED_W-1:0] p_sat;

  // stage 1: (n-1)*newest - sum of older centres, then sign and magnitude
  assign scaled = csum_t'(c1) * csum_t'(n1 - count_t'(1));
  assign total  = $signed({1'b0, scaled}) - $signed({1'b0, older1});
  assign neg    = total[NUM_W-1];
  assign mag    = neg ? NUM_W'(-total) : NUM_W'(total);
  assign num    = (mag << 1) + half_div(n1);

  // stage 2: reciprocal multiply, low by at most one
  assign prod = {{NUM_W{1'b0}}, num2} * {{NUM_W{1'b0}}, recip(n2)};

  // stage 3: correct the quotient, apply sign, clamp
  assign back   = {{NUM_W{1'b0}}, q0} * {{NUM_W{1'b0}}, twice_div(n3)};
  assign rem    = num3 - back[NUM_W-1:0];
  assign quo    = (rem >= twice_div(n3)) ? q0 + NUM_W'(1) : q0;
  assign offset = neg3 ? -$signed(EXT_W'(quo)) : $signed(EXT_W'(quo));
  assign p_full = $signed(EXT_W'(c3)) + offset;

  always_comb begin
    if (p_full > $signed(EXT_W'(PRED_MAX))) begin
      p_sat = PRED_W'(PRED_MAX);
    end else if (p_full < $signed(EXT_W'(PRED_MIN))) begin
      p_sat = PRED_W'(PRED_MIN);
    end else begin
      p_sat = PRED_W'(p_full);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      c1     <= center;
      older1 <= older;
      n1     <= n;
    end
    if (en.s2) begin
      c2   <= c1;
      n2   <= n1;
      num2 <= num;
      neg2 <= neg;
    end
    if (en.s3) begin
      c3   <= c2;
      n3   <= n2;
      num3 <= num2;
      neg3 <= neg2;
      q0   <= prod[2*NUM_W-1:NUM_W];
    end
    if (en.s4) begin
      center_q  <= c3;
      predicted <= p_sat;
    end
  end

endmodule
`default_nettype wire

>>> src/track_position_predictor.sv
// Track position predictor top level: centre history cells and two axis pipelines.
// Depends on tpp_pkg, tpp_cell, tpp_axis and track_position_predictor_defines.svh.
//
// Takes one bounding box per transfer and returns one result per box: the box
// centre ((2*left+width)/2, truncated), the predicted next centre and the number
// of centres the prediction used (1 to 5). The prediction is the newest centre
// plus the weighted mean of recent centre-to-centre steps (weights 1..n-1, newest
// heaviest), rounded half away from zero and clamped to the 15-bit signed range.
// A box with new_track set, or the first box after reset, starts a fresh track. The
// history is a row of four cells, newest first, that advance one place on each
// accepted box; their masked sum feeds the first pipeline stage. A box may be
// accepted every cycle while box_stall is low. Its result passes through stage 1
// weighting, stage 2 reciprocal multiply, stage 3 correction and clamp and stage 4
// output register, and waits there while result_stall holds the output. Each stage
// holds or advances on its own, so empty stages fill while a result waits.
`default_nettype none
module track_position_predictor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              box_valid,
  output logic                                   box_stall,
  input  wire logic                              new_track,
  input  wire logic [tpp_pkg::COORD_BITS-1:0]    box_left,
  input  wire logic [tpp_pkg::COORD_BITS-1:0]    box_top,
  input  wire logic [tpp_pkg::COORD_BITS-1:0]    box_width,
  input  wire logic [tpp_pkg::COORD_BITS-1:0]    box_height,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output tpp_pkg::center_t                       center_x,
  output tpp_pkg::center_t                       center_y,
  output logic signed [tpp_pkg::PRED_W-1:0]      predicted_x,
  output logic signed [tpp_pkg::PRED_W-1:0]      predicted_y,
  output tpp_pkg::count_t                        points_held
);
  import tpp_pkg::*;

`include "track_position_predictor_defines.svh"

  stage_en_t en;
  logic      v1, v2, v3, v4;
  logic      accept;
  count_t    cnt, n_new, kept;
  count_t    n1, n2, n3;
  logic      start;
  logic [CW:0] sum_cx, sum_cy;
  center_t   cx, cy;

  center_t   hx [HIST_CELLS];
  center_t   hy [HIST_CELLS];
  csum_t     sx [HIST_CELLS+1];
  csum_t     sy [HIST_CELLS+1];

  // Each stage advances when it is empty or the stage after it advances.
  assign en.s4  = !v4 || !result_stall;
  assign en.s3  = !v3 || en.s4;
  assign en.s2  = !v2 || en.s3;
  assign en.s1  = !v1 || en.s2;
  assign box_stall = !en.s1;
  assign accept    = box_valid && en.s1;
  assign result_valid = v4;

  // Centre of this box; drop the half pixel.
  assign sum_cx = {1'b0, box_left, 1'b0} + (CW+1)'(box_width);
  assign sum_cy = {1'b0, box_top,  1'b0} + (CW+1)'(box_height);
  assign cx     = sum_cx[CW:1];
  assign cy     = sum_cy[CW:1];

  // Count after this box: restart, grow, or stay saturated.
  assign start = new_track || (cnt == '0);
  always_comb begin
    if (start) begin
      n_new = count_t'(1);
    end else if (cnt >= count_t'(DEPTH)) begin
      n_new = count_t'(DEPTH);
    end else begin
      n_new = cnt + count_t'(1);
    end
  end
  assign kept = n_new - count_t'(1);   // older centres that join the prediction

  // History row, newest first; the first cell takes this box's centre.
  assign sx[0] = '0;
  assign sy[0] = '0;
  for (genvar j = 0; j < HIST_CELLS; j++) begin : g_cell
    center_t xin, yin;
    if (j == 0) begin : g_head
      assign xin = cx;
      assign yin = cy;
    end else begin : g_body
      assign xin = hx[j-1];
      assign yin = hy[j-1];
    end
    tpp_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .x_in     (xin),
      .y_in     (yin),
      .active   (count_t'(j) < kept),
      .sum_x_in (sx[j]),
      .sum_y_in (sy[j]),
      .x        (hx[j]),
      .y        (hy[j]),
      .sum_x    (sx[j+1]),
      .sum_y    (sy[j+1])
    );
  end

  tpp_axis u_axis_x (
    .clk       (clk),
    .en        (en),
    .center    (cx),
    .older     (sx[HIST_CELLS]),
    .n         (n_new),
    .center_q  (center_x),
    .predicted (predicted_x)
  );

  tpp_axis u_axis_y (
    .clk       (clk),
    .en        (en),
    .center    (cy),
    .older     (sy[HIST_CELLS]),
    .n         (n_new),
    .center_q  (center_y),
    .predicted (predicted_y)
  );

  // Control state: valid bits and the track length.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      cnt <= '0;
    end else begin
      if (en.s1) v1 <= box_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (accept) cnt <= n_new;
    end
  end

  // Centre count travels alongside the axis pipelines.
  always_ff @(posedge clk) begin
    if (en.s1) n1 <= n_new;
    if (en.s2) n2 <= n1;
    if (en.s3) n3 <= n2;
    if (en.s4) points_held <= n3;
  end

  `TPP_ASSERT(a_cnt_range, clk, rst, cnt <= count_t'(DEPTH))
  `TPP_ASSERT_NEXT(a_restart, clk, rst, accept && new_track, cnt == count_t'(1))
  `TPP_ASSERT(a_held, clk, rst, !v4 || (points_held != '0 && points_held <= count_t'(DEPTH)))
  `TPP_ASSERT_NEXT(a_stage_moves, clk, rst, v1 && en.s2, v2)

endmodule
`default_nettype wire
